FILE: rtl/core/dihedral_angle_unit_core_assert.svh
// Assertion macros for the dihedral angle unit checker.
// No dependencies; included by the checker file.
`ifndef DIHEDRAL_ANGLE_UNIT_CORE_ASSERT_SVH
`define DIHEDRAL_ANGLE_UNIT_CORE_ASSERT_SVH

// implication, masked during reset
`define DAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset cycle
`define DAU_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dau_pkg.sv
// Shared widths, constants, sideband type and arctangent table for the dihedral angle unit.
// No dependencies.
package dau_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
    localparam int LIMIT_WIDTH     = 48;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 48'd28147497671;

    localparam int BOND_WIDTH  = COORD_WIDTH + 1;
    localparam int BPROD_WIDTH = 2 * BOND_WIDTH;
    localparam int NORM_WIDTH  = BPROD_WIDTH + 1;
    localparam int NSPAN_BITS  = $clog2(NORM_WIDTH + 1);

    localparam int SHORT_BITS  = 25;
    localparam int SQ_WIDTH    = 2 * SHORT_BITS;
    localparam int SQSUM_WIDTH = SQ_WIDTH + 2;

    localparam int SPLIT_LO   = 26;
    localparam int SPLIT_HI   = NORM_WIDTH - SPLIT_LO;
    localparam int PH_WIDTH   = SPLIT_HI + BOND_WIDTH;
    localparam int PL_WIDTH   = SPLIT_LO + 1 + BOND_WIDTH;
    localparam int TP_WIDTH   = NORM_WIDTH + BOND_WIDTH + 3;

    localparam int UNIT_WIDTH    = 30;
    localparam int UNIT_SPAN_MAX = UNIT_WIDTH - 1;
    localparam int UPROD_WIDTH   = 2 * UNIT_WIDTH;
    localparam int Q_WIDTH       = UPROD_WIDTH + 2;
    localparam int QSPAN_BITS    = $clog2(Q_WIDTH + 1);

    localparam int RED_WIDTH    = 31;
    localparam int RED_SPAN_MAX = RED_WIDTH - 1;
    localparam int RAD_WIDTH    = 2 * RED_WIDTH;
    localparam int ROOT_WIDTH   = RED_WIDTH;
    localparam int REM_WIDTH    = ROOT_WIDTH + 2;
    localparam int SQRT_CELLS   = ROOT_WIDTH;

    localparam int CORDIC_WIDTH = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = 5;
    localparam int Z_FRAC_BITS  = 30;
    localparam logic signed [CORDIC_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam int ROUND_SHIFT  = Z_FRAC_BITS - ANGLE_FRAC_BITS;

    localparam int FRONT_STAGES = 11;
    localparam int SIDE_STAGES  = 6;
    localparam int DAU_LATENCY  = FRONT_STAGES + SQRT_CELLS + 1 + CORDIC_STEPS + 1;
    localparam int ANGLE_MAX    = 205887;

    typedef struct packed {
        logic valid;
        logic flip;
        logic degen;
    } t_side;

    function automatic logic signed [CORDIC_WIDTH-1:0] f_atan(input logic [STEP_BITS-1:0] k);
        case (k)
            5'd0:    f_atan = 34'sd843314857;
            5'd1:    f_atan = 34'sd497837829;
            5'd2:    f_atan = 34'sd263043837;
            5'd3:    f_atan = 34'sd133525159;
            5'd4:    f_atan = 34'sd67021687;
            5'd5:    f_atan = 34'sd33543516;
            5'd6:    f_atan = 34'sd16775851;
            5'd7:    f_atan = 34'sd8388437;
            5'd8:    f_atan = 34'sd4194283;
            5'd9:    f_atan = 34'sd2097149;
            default: f_atan = CORDIC_WIDTH'(34'd1 << (5'd30 - k));
        endcase
    endfunction

endpackage

FILE: rtl/core/dau_sqrt_cell.sv
// One digit cell of the pipelined integer square root: one root bit per word.
// Depends on dau_pkg.
module dau_sqrt_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [dau_pkg::REM_WIDTH-1:0]          i_rem,
    input  logic [dau_pkg::ROOT_WIDTH-1:0]         i_root,
    input  logic [dau_pkg::RAD_WIDTH-1:0]          i_rad,
    input  logic signed [dau_pkg::RED_WIDTH-1:0]   i_x,
    input  dau_pkg::t_side                         i_side,
    output logic [dau_pkg::REM_WIDTH-1:0]          o_rem,
    output logic [dau_pkg::ROOT_WIDTH-1:0]         o_root,
    output logic [dau_pkg::RAD_WIDTH-1:0]          o_rad,
    output logic signed [dau_pkg::RED_WIDTH-1:0]   o_x,
    output dau_pkg::t_side                         o_side
);

    logic [dau_pkg::REM_WIDTH+1:0] w_rem2;
    logic [dau_pkg::REM_WIDTH+1:0] w_trial;
    logic [dau_pkg::REM_WIDTH+1:0] w_diff;
    logic                          w_ge;
    logic [dau_pkg::REM_WIDTH-1:0] n_rem;
    logic [dau_pkg::ROOT_WIDTH-1:0] n_root;

    logic [dau_pkg::REM_WIDTH-1:0]         r_rem;
    logic [dau_pkg::ROOT_WIDTH-1:0]        r_root;
    logic [dau_pkg::RAD_WIDTH-1:0]         r_rad;
    logic signed [dau_pkg::RED_WIDTH-1:0]  r_x;
    dau_pkg::t_side                        r_side;

    always_comb begin
        w_rem2  = {i_rem, i_rad[dau_pkg::RAD_WIDTH-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_rem2 - w_trial;
        w_ge    = (w_rem2 >= w_trial);
        n_rem   = w_ge ? w_diff[dau_pkg::REM_WIDTH-1:0] : w_rem2[dau_pkg::REM_WIDTH-1:0];
        n_root  = {i_root[dau_pkg::ROOT_WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= {i_rad[dau_pkg::RAD_WIDTH-3:0], 2'b00};
        r_x    <= i_x;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_x    = r_x;
    assign o_side = r_side;

endmodule

FILE: rtl/core/dau_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on dau_pkg (widths, arctangent table, sideband type).
module dau_cordic_cell (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [dau_pkg::STEP_BITS-1:0]            i_step,
    input  logic signed [dau_pkg::CORDIC_WIDTH-1:0]  i_x,
    input  logic signed [dau_pkg::CORDIC_WIDTH-1:0]  i_y,
    input  logic signed [dau_pkg::CORDIC_WIDTH-1:0]  i_z,
    input  dau_pkg::t_side                           i_side,
    output logic signed [dau_pkg::CORDIC_WIDTH-1:0]  o_x,
    output logic signed [dau_pkg::CORDIC_WIDTH-1:0]  o_y,
    output logic signed [dau_pkg::CORDIC_WIDTH-1:0]  o_z,
    output dau_pkg::t_side                           o_side
);

    logic signed [dau_pkg::CORDIC_WIDTH-1:0] w_dx;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] w_dy;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] w_at;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] n_x;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] n_y;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] n_z;

    logic signed [dau_pkg::CORDIC_WIDTH-1:0] r_x;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] r_y;
    logic signed [dau_pkg::CORDIC_WIDTH-1:0] r_z;
    dau_pkg::t_side                          r_side;

    always_comb begin
        w_dx = i_y >>> i_step;
        w_dy = i_x >>> i_step;
        w_at = dau_pkg::f_atan(i_step);
        if (i_y > 0) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_at;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

FILE: rtl/core/dihedral_angle_unit_core.sv
// Top level of the dihedral angle unit: bond/normal front end, root cells, CORDIC cells.
// Depends on dau_pkg, dau_sqrt_cell and dau_cordic_cell.
//
// Usage:
//   Drive the twelve coordinates and raise start; a word is taken at every rising
//   edge with start high. busy is held low, so a new word may enter every cycle.
//   Each result appears on o_angle / o_degenerate for one cycle with o_valid high,
//   in the order in which the words were taken.
//   Throughput is one word per clock: the front end is eleven registered stages
//   (bond vectors, cross products, scaling, dot/cross of the normals), then one
//   square-root cell per root bit (31) and one CORDIC cell per rotation (30),
//   a swap stage and an output register.
//   The receiver cannot stall; results are not held.
//   degeneracy_limit is written with i_cfg_we / i_cfg_data while no word is in
//   flight; it takes effect at the next edge.
//   Reset (synchronous, active low) empties the pipeline and restores the limit.
module dihedral_angle_unit_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     i_cfg_we,
    input  logic [dau_pkg::LIMIT_WIDTH-1:0]          i_cfg_data,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p1_x,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p1_y,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p1_z,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p2_x,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p2_y,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p2_z,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p3_x,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p3_y,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p3_z,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p4_x,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p4_y,
    input  logic signed [dau_pkg::COORD_WIDTH-1:0]   i_p4_z,
    output logic                                     o_valid,
    output logic signed [dau_pkg::ANGLE_WIDTH-1:0]   o_angle,
    output logic                                     o_degenerate
);

    localparam int CW   = dau_pkg::COORD_WIDTH;
    localparam int BW   = dau_pkg::BOND_WIDTH;
    localparam int PW   = dau_pkg::BPROD_WIDTH;
    localparam int NW   = dau_pkg::NORM_WIDTH;
    localparam int SPN  = dau_pkg::NSPAN_BITS;
    localparam int SQW  = dau_pkg::SQ_WIDTH;
    localparam int SSW  = dau_pkg::SQSUM_WIDTH;
    localparam int UW   = dau_pkg::UNIT_WIDTH;
    localparam int UPW  = dau_pkg::UPROD_WIDTH;
    localparam int QW   = dau_pkg::Q_WIDTH;
    localparam int SPQ  = dau_pkg::QSPAN_BITS;
    localparam int RW   = dau_pkg::RED_WIDTH;
    localparam int RADW = dau_pkg::RAD_WIDTH;
    localparam int ZW   = dau_pkg::CORDIC_WIDTH;
    localparam int TPW  = dau_pkg::TP_WIDTH;
    localparam int LO   = dau_pkg::SPLIT_LO;
    localparam int SB   = dau_pkg::SHORT_BITS;

    function automatic logic [SPN-1:0] f_lead_n(input logic [NW-1:0] t);
        logic [SPN-1:0] r;
        r = '0;
        for (int i = 0; i < NW; i++) begin
            if (t[i]) r = SPN'(i + 1);
        end
        return r;
    endfunction

    function automatic logic [SPQ-1:0] f_lead_q(input logic [QW-1:0] t);
        logic [SPQ-1:0] r;
        r = '0;
        for (int i = 0; i < QW; i++) begin
            if (t[i]) r = SPQ'(i + 1);
        end
        return r;
    endfunction

    logic [dau_pkg::LIMIT_WIDTH-1:0] r_limit;
    logic [3:0]                      r_vld;

    logic signed [CW-1:0] w_p [12];

    logic signed [BW-1:0] r1_b1 [3];
    logic signed [BW-1:0] r1_b2 [3];
    logic signed [BW-1:0] r1_b3 [3];

    logic signed [PW-1:0] r2_pa [3];
    logic signed [PW-1:0] r2_pb [3];
    logic signed [PW-1:0] r2_qa [3];
    logic signed [PW-1:0] r2_qb [3];
    logic signed [BW-1:0] r2_b3 [3];

    logic signed [NW-1:0] r3_n1 [3];
    logic signed [NW-1:0] r3_n2 [3];
    logic signed [BW-1:0] r3_b3 [3];

    logic signed [NW-1:0]               r4_n1 [3];
    logic signed [NW-1:0]               r4_n2 [3];
    logic [2:0]                         r4_fit1;
    logic [2:0]                         r4_fit2;
    logic [SQW-1:0]                     r4_sq1 [3];
    logic [SQW-1:0]                     r4_sq2 [3];
    logic signed [dau_pkg::PH_WIDTH-1:0] r4_ph [3];
    logic signed [dau_pkg::PL_WIDTH-1:0] r4_pl [3];
    logic [SPN-1:0]                     r4_span1;
    logic [SPN-1:0]                     r4_span2;

    logic [NW-1:0] w_t1;
    logic [NW-1:0] w_t2;

    logic signed [UW-1:0] r5_u [3];
    logic signed [UW-1:0] r5_v [3];
    dau_pkg::t_side       r5_side;
    dau_pkg::t_side       n5_side;
    logic [SSW-1:0]       w_sum1;
    logic [SSW-1:0]       w_sum2;
    logic signed [TPW-1:0] w_tp;
    logic [SPN-1:0]       w_s1;
    logic [SPN-1:0]       w_s2;

    logic signed [UPW-1:0] r6_m [3][3];
    logic signed [QW-1:0]  r7_q [4];
    logic signed [QW-1:0]  r8_q [4];
    logic [SPQ-1:0]        r8_sh;
    logic [QW-1:0]         w_tq;
    logic [SPQ-1:0]        w_spq;
    logic signed [RW-1:0]  r9_r [4];
    logic [RADW-1:0]       r10_sq [3];
    logic signed [RW-1:0]  r10_x;
    logic [RADW-1:0]       r11_sq;
    logic signed [RW-1:0]  r11_x;

    dau_pkg::t_side r_side [dau_pkg::SIDE_STAGES];

    logic [dau_pkg::REM_WIDTH-1:0]  w_rem  [dau_pkg::SQRT_CELLS+1];
    logic [dau_pkg::ROOT_WIDTH-1:0] w_root [dau_pkg::SQRT_CELLS+1];
    logic [RADW-1:0]                w_rad  [dau_pkg::SQRT_CELLS+1];
    logic signed [RW-1:0]           w_x    [dau_pkg::SQRT_CELLS+1];
    dau_pkg::t_side                 w_sside [dau_pkg::SQRT_CELLS+1];

    logic signed [ZW-1:0] r12_x;
    logic signed [ZW-1:0] r12_y;
    logic signed [ZW-1:0] r12_z;
    dau_pkg::t_side       r12_side;

    logic signed [ZW-1:0] w_cx [dau_pkg::CORDIC_STEPS+1];
    logic signed [ZW-1:0] w_cy [dau_pkg::CORDIC_STEPS+1];
    logic signed [ZW-1:0] w_cz [dau_pkg::CORDIC_STEPS+1];
    dau_pkg::t_side       w_cside [dau_pkg::CORDIC_STEPS+1];

    logic signed [ZW-1:0] w_zr;
    logic signed [ZW-1:0] w_mag;
    logic signed [ZW-1:0] w_ang;

    logic                                   r_valid;
    logic signed [dau_pkg::ANGLE_WIDTH-1:0] r_angle;
    logic                                   r_degen;

    assign busy = 1'b0;

    assign w_p[0]  = i_p1_x;
    assign w_p[1]  = i_p1_y;
    assign w_p[2]  = i_p1_z;
    assign w_p[3]  = i_p2_x;
    assign w_p[4]  = i_p2_y;
    assign w_p[5]  = i_p2_z;
    assign w_p[6]  = i_p3_x;
    assign w_p[7]  = i_p3_y;
    assign w_p[8]  = i_p3_z;
    assign w_p[9]  = i_p4_x;
    assign w_p[10] = i_p4_y;
    assign w_p[11] = i_p4_z;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= dau_pkg::LIMIT_RESET;
            r_vld   <= '0;
            r5_side <= '0;
            for (int i = 0; i < dau_pkg::SIDE_STAGES; i++) r_side[i] <= '0;
            r12_side <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_vld     <= {r_vld[2:0], start & ~busy};
            r5_side   <= n5_side;
            r_side[0] <= r5_side;
            for (int i = 1; i < dau_pkg::SIDE_STAGES; i++) r_side[i] <= r_side[i-1];
            r12_side  <= w_sside[dau_pkg::SQRT_CELLS];
            r_valid   <= w_cside[dau_pkg::CORDIC_STEPS].valid;
        end
    end

    // stages 1 to 4: bonds, cross products, normals, squares and partial triple product
    always_comb begin
        w_t1 = '0;
        w_t2 = '0;
        for (int k = 0; k < 3; k++) begin
            w_t1 = w_t1 | (r3_n1[k] ^ {NW{r3_n1[k][NW-1]}});
            w_t2 = w_t2 | (r3_n2[k] ^ {NW{r3_n2[k][NW-1]}});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_b1[k] <= BW'(w_p[k]) - BW'(w_p[3+k]);
            r1_b2[k] <= BW'(w_p[6+k]) - BW'(w_p[3+k]);
            r1_b3[k] <= BW'(w_p[9+k]) - BW'(w_p[6+k]);
        end

        r2_pa[0] <= PW'(r1_b1[1]) * PW'(r1_b2[2]);
        r2_pb[0] <= PW'(r1_b1[2]) * PW'(r1_b2[1]);
        r2_pa[1] <= PW'(r1_b1[2]) * PW'(r1_b2[0]);
        r2_pb[1] <= PW'(r1_b1[0]) * PW'(r1_b2[2]);
        r2_pa[2] <= PW'(r1_b1[0]) * PW'(r1_b2[1]);
        r2_pb[2] <= PW'(r1_b1[1]) * PW'(r1_b2[0]);
        r2_qa[0] <= PW'(r1_b3[1]) * PW'(r1_b2[2]);
        r2_qb[0] <= PW'(r1_b3[2]) * PW'(r1_b2[1]);
        r2_qa[1] <= PW'(r1_b3[2]) * PW'(r1_b2[0]);
        r2_qb[1] <= PW'(r1_b3[0]) * PW'(r1_b2[2]);
        r2_qa[2] <= PW'(r1_b3[0]) * PW'(r1_b2[1]);
        r2_qb[2] <= PW'(r1_b3[1]) * PW'(r1_b2[0]);
        for (int k = 0; k < 3; k++) r2_b3[k] <= r1_b3[k];

        for (int k = 0; k < 3; k++) begin
            r3_n1[k] <= NW'(r2_pa[k]) - NW'(r2_pb[k]);
            r3_n2[k] <= NW'(r2_qa[k]) - NW'(r2_qb[k]);
            r3_b3[k] <= r2_b3[k];
        end

        for (int k = 0; k < 3; k++) begin
            r4_n1[k]   <= r3_n1[k];
            r4_n2[k]   <= r3_n2[k];
            r4_fit1[k] <= (&r3_n1[k][NW-1:SB-1]) | ~(|r3_n1[k][NW-1:SB-1]);
            r4_fit2[k] <= (&r3_n2[k][NW-1:SB-1]) | ~(|r3_n2[k][NW-1:SB-1]);
            r4_sq1[k]  <= SQW'($signed(r3_n1[k][SB-1:0])) * SQW'($signed(r3_n1[k][SB-1:0]));
            r4_sq2[k]  <= SQW'($signed(r3_n2[k][SB-1:0])) * SQW'($signed(r3_n2[k][SB-1:0]));
            r4_ph[k]   <= dau_pkg::PH_WIDTH'($signed(r3_n1[k][NW-1:LO]))
                          * dau_pkg::PH_WIDTH'(r3_b3[k]);
            r4_pl[k]   <= dau_pkg::PL_WIDTH'($signed({1'b0, r3_n1[k][LO-1:0]}))
                          * dau_pkg::PL_WIDTH'(r3_b3[k]);
        end
        r4_span1 <= f_lead_n(w_t1);
        r4_span2 <= f_lead_n(w_t2);
    end

    // stage 5: degeneracy, orientation, normal scaling
    always_comb begin
        w_sum1 = '0;
        w_sum2 = '0;
        w_tp   = '0;
        for (int k = 0; k < 3; k++) begin
            w_sum1 = w_sum1 + SSW'(r4_sq1[k]);
            w_sum2 = w_sum2 + SSW'(r4_sq2[k]);
            w_tp   = w_tp + (TPW'(r4_ph[k]) <<< LO) + TPW'(r4_pl[k]);
        end
        w_s1 = (r4_span1 > SPN'(dau_pkg::UNIT_SPAN_MAX)) ?
               r4_span1 - SPN'(dau_pkg::UNIT_SPAN_MAX) : '0;
        w_s2 = (r4_span2 > SPN'(dau_pkg::UNIT_SPAN_MAX)) ?
               r4_span2 - SPN'(dau_pkg::UNIT_SPAN_MAX) : '0;
        n5_side.valid = r_vld[3];
        n5_side.flip  = ~w_tp[TPW-1] && (w_tp != '0);
        n5_side.degen = (&r4_fit1 && (w_sum1 < SSW'(r_limit)))
                     || (&r4_fit2 && (w_sum2 < SSW'(r_limit)));
    end

    // stages 5 to 11: scaled dot and cross of the normals, squared length
    always_comb begin
        w_tq = '0;
        for (int k = 0; k < 4; k++) w_tq = w_tq | (r7_q[k] ^ {QW{r7_q[k][QW-1]}});
        w_spq = f_lead_q(w_tq);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r5_u[k] <= UW'(r4_n1[k] >>> w_s1);
            r5_v[k] <= UW'(r4_n2[k] >>> w_s2);
        end

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) r6_m[i][j] <= UPW'(r5_u[i]) * UPW'(r5_v[j]);
        end

        r7_q[0] <= QW'(r6_m[0][0]) + QW'(r6_m[1][1]) + QW'(r6_m[2][2]);
        r7_q[1] <= QW'(r6_m[1][2]) - QW'(r6_m[2][1]);
        r7_q[2] <= QW'(r6_m[2][0]) - QW'(r6_m[0][2]);
        r7_q[3] <= QW'(r6_m[0][1]) - QW'(r6_m[1][0]);

        for (int k = 0; k < 4; k++) r8_q[k] <= r7_q[k];
        r8_sh <= (w_spq > SPQ'(dau_pkg::RED_SPAN_MAX)) ?
                 w_spq - SPQ'(dau_pkg::RED_SPAN_MAX) : '0;

        for (int k = 0; k < 4; k++) r9_r[k] <= RW'(r8_q[k] >>> r8_sh);

        for (int k = 0; k < 3; k++) r10_sq[k] <= RADW'(r9_r[k+1]) * RADW'(r9_r[k+1]);
        r10_x <= r9_r[0];

        r11_sq <= r10_sq[0] + r10_sq[1] + r10_sq[2];
        r11_x  <= r10_x;
    end

    // square root cells
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_rad[0]   = r11_sq;
    assign w_x[0]     = r11_x;
    assign w_sside[0] = r_side[dau_pkg::SIDE_STAGES-1];

    for (genvar g = 0; g < dau_pkg::SQRT_CELLS; g++) begin : g_sqrt
        dau_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_rad   (w_rad[g]),
            .i_x     (w_x[g]),
            .i_side  (w_sside[g]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_x     (w_x[g+1]),
            .o_side  (w_sside[g+1])
        );
    end

    // fold the left half plane onto the right
    always_ff @(posedge i_clk) begin
        if (w_x[dau_pkg::SQRT_CELLS] < 0) begin
            r12_x <= ZW'(w_root[dau_pkg::SQRT_CELLS]);
            r12_y <= -ZW'(w_x[dau_pkg::SQRT_CELLS]);
            r12_z <= dau_pkg::HALF_PI_Q30;
        end else begin
            r12_x <= ZW'(w_x[dau_pkg::SQRT_CELLS]);
            r12_y <= ZW'(w_root[dau_pkg::SQRT_CELLS]);
            r12_z <= '0;
        end
    end

    // CORDIC cells
    assign w_cx[0]    = r12_x;
    assign w_cy[0]    = r12_y;
    assign w_cz[0]    = r12_z;
    assign w_cside[0] = r12_side;

    for (genvar g = 0; g < dau_pkg::CORDIC_STEPS; g++) begin : g_cordic
        dau_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (dau_pkg::STEP_BITS'(g)),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .i_side  (w_cside[g]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1]),
            .o_side  (w_cside[g+1])
        );
    end

    // round, clamp, sign
    always_comb begin
        w_zr  = w_cz[dau_pkg::CORDIC_STEPS] + (ZW'(1) <<< (dau_pkg::ROUND_SHIFT - 1));
        w_mag = w_zr >>> dau_pkg::ROUND_SHIFT;
        if (w_mag < 0) w_mag = '0;
        w_ang = w_cside[dau_pkg::CORDIC_STEPS].flip ? -w_mag : w_mag;
    end

    always_ff @(posedge i_clk) begin
        r_degen <= w_cside[dau_pkg::CORDIC_STEPS].degen;
        r_angle <= w_cside[dau_pkg::CORDIC_STEPS].degen ? '0 : w_ang[dau_pkg::ANGLE_WIDTH-1:0];
    end

    assign o_valid      = r_valid;
    assign o_angle      = r_angle;
    assign o_degenerate = r_degen;

endmodule

FILE: rtl/core/dau_checker.sv
// Port-level checker for the dihedral angle unit, bound to the top level.
// Depends on dau_pkg and dihedral_angle_unit_core_assert.svh.
`include "dihedral_angle_unit_core_assert.svh"

module dau_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   o_valid,
    input logic signed [dau_pkg::ANGLE_WIDTH-1:0] o_angle,
    input logic                                   o_degenerate
);

    `DAU_ASSERT_IMPL(a_word_out, start && !busy, ##(dau_pkg::DAU_LATENCY) o_valid, "word lost")
    `DAU_ASSERT_IMPL(a_word_in, o_valid, $past(start && !busy, dau_pkg::DAU_LATENCY), "spurious word")
    `DAU_ASSERT_IMPL(a_degen_zero, o_valid && o_degenerate, o_angle == '0, "degenerate angle not zero")
    `DAU_ASSERT_IMPL(a_range, o_valid, (o_angle <= dau_pkg::ANGLE_MAX) && (o_angle >= -dau_pkg::ANGLE_MAX), "angle out of range")
    `DAU_ASSERT_RESET(a_reset, !o_valid, "result after reset")

endmodule

bind dihedral_angle_unit_core dau_checker u_dau_checker (.*);
